### rtl/mips_lite_execute_unit_macros.svh
// Assertion macros used by the execute unit top level.
`ifndef MIPS_LITE_EXECUTE_UNIT_MACROS_SVH
`define MIPS_LITE_EXECUTE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define MLX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mlx assertion failed");

`define MLX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mlx assertion failed");

`else

`define MLX_ASSERT_IMP(lbl, ante, cons)
`define MLX_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### rtl/mlx_pkg.sv
// Types, constants and helpers of the MIPS-lite execute unit.
`default_nettype none

package mlx_pkg;

  localparam int unsigned MEM_WORDS = 1024;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_N     = 32;
  localparam int unsigned REG_AW    = 5;
  localparam int unsigned IMM_W     = 16;
  localparam int unsigned MIDX_W    = 10;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EXEC = 1'b1;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,  OP_ADDI = 5'd1,  OP_SUB  = 5'd2,  OP_SUBI = 5'd3,
    OP_MUL  = 5'd4,  OP_MULI = 5'd5,  OP_OR   = 5'd6,  OP_ORI  = 5'd7,
    OP_AND  = 5'd8,  OP_ANDI = 5'd9,  OP_XOR  = 5'd10, OP_XORI = 5'd11,
    OP_LDW  = 5'd12, OP_STW  = 5'd13, OP_BZ   = 5'd14, OP_BEQ  = 5'd15,
    OP_JR   = 5'd16, OP_HALT = 5'd17, OP_NOP  = 5'd18
  } opcode_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_UNALIGNED = 3'd1,
    ERR_RANGE     = 3'd2,
    ERR_UNKNOWN   = 3'd3,
    ERR_HALTED    = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    CLS_ARITH = 3'd0,
    CLS_LOGIC = 3'd1,
    CLS_MEM   = 3'd2,
    CLS_CTRL  = 3'd3,
    CLS_NOP   = 3'd4
  } class_e;

  typedef struct packed {
    logic                    cmd;
    logic [4:0]              opcode;
    logic [REG_AW-1:0]       rs;
    logic [REG_AW-1:0]       rt;
    logic [REG_AW-1:0]       rd;
    logic signed [IMM_W-1:0] imm;
    logic [MIDX_W-1:0]       img_idx;
    logic [XLEN-1:0]         img_word;
  } item_t;

  // result of one item as it travels to the output
  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic              halted;
    err_e              err;
    logic              taken;
    logic              rw;
    logic [REG_AW-1:0] ridx;
    logic [XLEN-1:0]   rval;
    logic              ld;
    logic              mw;
    logic [MIDX_W-1:0] midx;
    logic [XLEN-1:0]   mval;
    class_e            cls;
  } exec_t;

  // data memory access issued when an item leaves execute
  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [XLEN-1:0]   wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

  function automatic class_e class_of(logic [4:0] op);
    class_e c;
    if (op <= OP_MULI) begin
      c = CLS_ARITH;
    end else if (op <= OP_XORI) begin
      c = CLS_LOGIC;
    end else if (op <= OP_STW) begin
      c = CLS_MEM;
    end else if (op == OP_NOP) begin
      c = CLS_NOP;
    end else begin
      c = CLS_CTRL;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/mips_lite_execute_unit.sv
// Top level of the MIPS-lite execute unit: pipeline, forwarding and output register.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------------
//  in      | input     | in_valid_i / in_ready_o  | command, opcode, regs, imm, image data
//  out     | output    | out_valid_o / out_ready_i| next_pc, flags, reg/mem writes, class
//
// One item is accepted per cycle unless the sweep or output backpressure stalls input; each
// result passes the execute stage, the memory/writeback stage and the output register.
// The register file and data memory are synchronous RAMs; results of the item ahead
// are forwarded into execute, including load data straight from the memory read port.
// After reset a sweep zeroes the data memory: in_ready_o stays low until all MEM_WORDS
// (1024) words are cleared. Output backpressure stalls the writeback stage, then execute, then input.
`default_nettype none
`include "mips_lite_execute_unit_macros.svh"

module mips_lite_execute_unit
  import mlx_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               command_i,
  input  wire logic [4:0]         opcode_i,
  input  wire logic [4:0]         src_reg_i,
  input  wire logic [4:0]         second_reg_i,
  input  wire logic [4:0]         dest_reg_i,
  input  wire logic signed [15:0] imm_value_i,
  input  wire logic [9:0]         image_index_i,
  input  wire logic [31:0]        image_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [31:0]             next_pc_o,
  output logic                    halted_o,
  output logic [2:0]              error_code_o,
  output logic                    branch_taken_o,
  output logic                    reg_write_o,
  output logic [4:0]              reg_index_o,
  output logic signed [31:0]      reg_value_o,
  output logic                    mem_write_o,
  output logic [9:0]              mem_index_o,
  output logic signed [31:0]      mem_value_o,
  output logic [2:0]              instr_class_o
);

  item_t           s1_q;
  logic            s1_valid_q, s1_valid_d;
  exec_t           s2_q;
  logic            s2_valid_q, s2_valid_d;
  exec_t           out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [XLEN-1:0] pc_q;
  logic            halt_q;

  logic            in_xfer, s1_move, s2_move;
  logic [XLEN-1:0] rf_a, rf_b, op_a, op_b;
  logic [XLEN-1:0] s2_val, dm_rdata;
  logic            dm_busy;
  logic            rf_we;
  logic [REG_AW-1:0] rf_waddr;
  exec_t           ex_res;
  mem_req_t        ex_mreq;
  item_t           in_item;

  assign in_item = '{
    cmd:      command_i,
    opcode:   opcode_i,
    rs:       src_reg_i,
    rt:       second_reg_i,
    rd:       dest_reg_i,
    imm:      imm_value_i,
    img_idx:  image_index_i,
    img_word: image_word_i
  };

  assign s2_move    = s2_valid_q & (~out_valid_q | out_ready_i);
  assign s1_move    = s1_valid_q & (~s2_valid_q | s2_move);
  assign in_ready_o = ~dm_busy & (~s1_valid_q | s1_move);
  assign in_xfer    = in_valid_i & in_ready_o;

  // writeback value of the item in stage 2; loads take it from the memory port
  assign s2_val   = s2_q.ld ? dm_rdata : s2_q.rval;
  assign rf_we    = s2_move & s2_q.rw;
  assign rf_waddr = s2_q.ridx;

  mlx_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (in_xfer),
    .raddr_a_i (src_reg_i),
    .raddr_b_i (second_reg_i),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (s2_val),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b)
  );

  always_comb begin
    op_a = rf_a;
    op_b = rf_b;
    if (s2_valid_q && s2_q.rw && s2_q.ridx == s1_q.rs) begin
      op_a = s2_val;
    end
    if (s2_valid_q && s2_q.rw && s2_q.ridx == s1_q.rt) begin
      op_b = s2_val;
    end
  end

  mlx_exec u_exec (
    .item_i (s1_q),
    .a_i    (op_a),
    .b_i    (op_b),
    .pc_i   (pc_q),
    .halt_i (halt_q),
    .res_o  (ex_res),
    .mreq_o (ex_mreq)
  );

  mlx_dmem u_dmem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (ex_mreq),
    .req_en_i (s1_move),
    .rdata_o  (dm_rdata),
    .busy_o   (dm_busy)
  );

  always_comb begin
    out_d      = s2_q;
    out_d.rval = s2_q.rw ? s2_val : '0;
    out_d.ld   = 1'b0;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s1_move) begin
      s2_valid_d = 1'b1;
    end else if (s2_move) begin
      s2_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      halt_q      <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_move) begin
        pc_q   <= ex_res.next_pc;
        halt_q <= ex_res.halted;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_item;
    end
    if (s1_move) begin
      s2_q <= ex_res;
    end
    if (s2_move) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign next_pc_o      = out_q.next_pc;
  assign halted_o       = out_q.halted;
  assign error_code_o   = out_q.err;
  assign branch_taken_o = out_q.taken;
  assign reg_write_o    = out_q.rw;
  assign reg_index_o    = out_q.ridx;
  assign reg_value_o    = out_q.rval;
  assign mem_write_o    = out_q.mw;
  assign mem_index_o    = out_q.midx;
  assign mem_value_o    = out_q.mval;
  assign instr_class_o  = out_q.cls;

  `MLX_ASSERT_IMP(a_no_r0_write, rf_we, rf_waddr != '0)
  `MLX_ASSERT_NXT(a_halt_sticky, halt_q, halt_q)
  `MLX_ASSERT_IMP(a_no_move_in_clear, dm_busy, !s1_move)
  `MLX_ASSERT_NXT(a_halted_err, s1_move && s1_q.cmd == CMD_EXEC && halt_q, s2_q.err == ERR_HALTED)

endmodule

`default_nettype wire

### rtl/mlx_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mlx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/mlx_regfile.sv
// Register file: two RAM copies for two read ports, valid bits, write bypass.
`default_nettype none

module mlx_regfile
  import mlx_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              re_i,
  input  wire logic [REG_AW-1:0] raddr_a_i,
  input  wire logic [REG_AW-1:0] raddr_b_i,
  input  wire logic              we_i,
  input  wire logic [REG_AW-1:0] waddr_i,
  input  wire logic [XLEN-1:0]   wdata_i,
  output logic      [XLEN-1:0]   rdata_a_o,
  output logic      [XLEN-1:0]   rdata_b_o
);

  logic [REG_N-1:0]  vld_q;
  logic              vld_a_q, vld_b_q;
  logic [REG_AW-1:0] raddr_a_q, raddr_b_q;
  logic              wb_vld_q;
  logic [REG_AW-1:0] wb_idx_q;
  logic [XLEN-1:0]   wb_data_q;
  logic [XLEN-1:0]   ram_a, ram_b;

  mlx_ram #(.WIDTH(XLEN), .DEPTH(REG_N)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (re_i),
    .raddr_i (raddr_a_i),
    .rdata_o (ram_a)
  );

  mlx_ram #(.WIDTH(XLEN), .DEPTH(REG_N)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (re_i),
    .raddr_i (raddr_b_i),
    .rdata_o (ram_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      wb_vld_q <= 1'b0;
      vld_a_q  <= 1'b0;
      vld_b_q  <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
        wb_vld_q       <= 1'b1;
      end
      if (re_i) begin
        vld_a_q <= vld_q[raddr_a_i];
        vld_b_q <= vld_q[raddr_b_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      wb_idx_q  <= waddr_i;
      wb_data_q <= wdata_i;
    end
    if (re_i) begin
      raddr_a_q <= raddr_a_i;
      raddr_b_q <= raddr_b_i;
    end
  end

  // the RAM returns old data on a write in the read cycle; the last write covers it
  always_comb begin
    if (wb_vld_q && wb_idx_q == raddr_a_q) begin
      rdata_a_o = wb_data_q;
    end else begin
      rdata_a_o = vld_a_q ? ram_a : '0;
    end
    if (wb_vld_q && wb_idx_q == raddr_b_q) begin
      rdata_b_o = wb_data_q;
    end else begin
      rdata_b_o = vld_b_q ? ram_b : '0;
    end
  end

endmodule

`default_nettype wire

### rtl/mlx_dmem.sv
// Data memory with a zeroing sweep after reset.
`default_nettype none

module mlx_dmem
  import mlx_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire mem_req_t   req_i,
  input  wire logic       req_en_i,
  output logic [XLEN-1:0] rdata_o,
  output logic            busy_o
);

  logic              clr_busy_q;
  logic [MEM_AW-1:0] clr_idx_q;
  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr;
  logic [XLEN-1:0]   ram_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == MEM_AW'(MEM_WORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
      ram_wdata = '0;
    end else begin
      ram_we    = req_en_i & req_i.we;
      ram_waddr = req_i.waddr;
      ram_wdata = req_i.wdata;
    end
  end

  mlx_ram #(.WIDTH(XLEN), .DEPTH(MEM_WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (req_en_i & req_i.re),
    .raddr_i (req_i.raddr),
    .rdata_o (rdata_o)
  );

  assign busy_o = clr_busy_q;

endmodule

`default_nettype wire

### rtl/mlx_exec.sv
// Execute logic: ALU, address and range checks, branch and halt decisions.
`default_nettype none

module mlx_exec
  import mlx_pkg::*;
(
  input  wire item_t           item_i,
  input  wire logic [XLEN-1:0] a_i,
  input  wire logic [XLEN-1:0] b_i,
  input  wire logic [XLEN-1:0] pc_i,
  input  wire logic            halt_i,
  output exec_t                res_o,
  output mem_req_t             mreq_o
);

  logic [XLEN-1:0]   imm_ext;
  logic [XLEN-1:0]   opb;
  logic [XLEN-1:0]   prod;
  logic [XLEN-1:0]   addr;
  logic [XLEN-3:0]   widx;
  logic              in_range;
  logic [XLEN-1:0]   img_ext;
  logic              img_in_range;
  logic [XLEN-1:0]   br_target;
  logic [REG_AW-1:0] dst;
  logic              wr;
  logic [XLEN-1:0]   val;

  assign imm_ext      = XLEN'(item_i.imm);
  // immediate forms have odd opcodes among the ALU ops
  assign opb          = item_i.opcode[0] ? imm_ext : b_i;
  assign prod         = XLEN'(a_i * opb);
  assign addr         = a_i + imm_ext;
  assign widx         = addr[XLEN-1:2];
  assign in_range     = widx < (XLEN-2)'(MEM_WORDS);
  assign img_ext      = XLEN'(item_i.img_idx);
  assign img_in_range = img_ext < XLEN'(MEM_WORDS);
  assign br_target    = pc_i + {imm_ext[XLEN-3:0], 2'b00};

  always_comb begin
    res_o         = '0;
    res_o.next_pc = pc_i;
    res_o.halted  = halt_i;
    res_o.err     = ERR_NONE;
    res_o.cls     = class_of(item_i.opcode);
    mreq_o        = '0;
    dst           = item_i.opcode[0] ? item_i.rt : item_i.rd;
    wr            = 1'b0;
    val           = '0;

    if (item_i.cmd == CMD_LOAD) begin
      res_o.cls = CLS_NOP;
      if (img_in_range) begin
        mreq_o.we    = 1'b1;
        mreq_o.waddr = img_ext[MEM_AW-1:0];
        mreq_o.wdata = item_i.img_word;
      end else begin
        res_o.err = ERR_RANGE;
      end
    end else if (halt_i) begin
      res_o.err = ERR_HALTED;
    end else begin
      res_o.next_pc = pc_i + XLEN'(4);
      case (item_i.opcode)
        OP_ADD, OP_ADDI: begin
          val = a_i + opb;
          wr  = 1'b1;
        end
        OP_SUB, OP_SUBI: begin
          val = a_i - opb;
          wr  = 1'b1;
        end
        OP_MUL, OP_MULI: begin
          val = prod;
          wr  = 1'b1;
        end
        OP_OR, OP_ORI: begin
          val = a_i | opb;
          wr  = 1'b1;
        end
        OP_AND, OP_ANDI: begin
          val = a_i & opb;
          wr  = 1'b1;
        end
        OP_XOR, OP_XORI: begin
          val = a_i ^ opb;
          wr  = 1'b1;
        end
        OP_LDW, OP_STW: begin
          // out of range wins over unaligned, and skips the access
          if (!in_range) begin
            res_o.err = ERR_RANGE;
          end else begin
            res_o.err = (addr[1:0] != 2'b00) ? ERR_UNALIGNED : ERR_NONE;
            if (item_i.opcode == OP_LDW) begin
              res_o.ld     = 1'b1;
              mreq_o.re    = 1'b1;
              mreq_o.raddr = addr[MEM_AW+1:2];
              dst          = item_i.rt;
              wr           = 1'b1;
            end else begin
              mreq_o.we    = 1'b1;
              mreq_o.waddr = addr[MEM_AW+1:2];
              mreq_o.wdata = b_i;
              res_o.mw     = 1'b1;
              res_o.midx   = widx[MIDX_W-1:0];
              res_o.mval   = b_i;
            end
          end
        end
        OP_BZ: begin
          if (a_i == '0) begin
            res_o.next_pc = br_target;
            res_o.taken   = 1'b1;
          end
        end
        OP_BEQ: begin
          if (a_i == b_i) begin
            res_o.next_pc = br_target;
            res_o.taken   = 1'b1;
          end
        end
        OP_JR: begin
          res_o.next_pc = a_i;
          res_o.taken   = 1'b1;
        end
        OP_HALT: begin
          res_o.halted = 1'b1;
        end
        OP_NOP: begin
        end
        default: begin
          res_o.err     = ERR_UNKNOWN;
          res_o.halted  = 1'b1;
          res_o.next_pc = pc_i;
        end
      endcase
      // register zero is never written
      if (wr && dst != '0) begin
        res_o.rw   = 1'b1;
        res_o.ridx = dst;
        res_o.rval = res_o.ld ? '0 : val;
      end
    end
  end

endmodule

`default_nettype wire

### tb/mlx_exec_checker.sv
// Checker for the MIPS-lite execute unit: tracks architectural state and compares every result.
module mlx_exec_checker
  import mlx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic        command_i,
  input  logic [4:0]  opcode_i,
  input  logic [4:0]  src_reg_i,
  input  logic [4:0]  second_reg_i,
  input  logic [4:0]  dest_reg_i,
  input  logic [15:0] imm_value_i,
  input  logic [9:0]  image_index_i,
  input  logic [31:0] image_word_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [31:0] next_pc_o,
  input  logic        halted_o,
  input  logic [2:0]  error_code_o,
  input  logic        branch_taken_o,
  input  logic        reg_write_o,
  input  logic [4:0]  reg_index_o,
  input  logic [31:0] reg_value_o,
  input  logic        mem_write_o,
  input  logic [9:0]  mem_index_o,
  input  logic [31:0] mem_value_o,
  input  logic [2:0]  instr_class_o,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic [2:0]  err;
    logic        taken;
    logic        rw;
    logic [4:0]  ridx;
    logic [31:0] rval;
    logic        mw;
    logic [9:0]  midx;
    logic [31:0] mval;
    logic [2:0]  cls;
  } exec_result_t;

  logic [31:0]  gpr [32];
  logic [31:0]  dmem [MEM_WORDS];
  logic [31:0]  pc_q;
  logic         halted_q;
  exec_result_t expected_results [$];
  exec_result_t got;
  exec_result_t want;
  int           fails;
  int           reported;

  function automatic logic [2:0] op_class(logic [4:0] op);
    if (op <= OP_MULI) return CLS_ARITH;
    if (op <= OP_XORI) return CLS_LOGIC;
    if (op <= OP_STW)  return CLS_MEM;
    if (op == OP_NOP)  return CLS_NOP;
    return CLS_CTRL;
  endfunction

  // Applies one transfer to the tracked state and returns the result it must produce.
  function automatic exec_result_t execute_item(logic cmd, logic [4:0] op, logic [4:0] rs,
                                                logic [4:0] rt, logic [4:0] rd,
                                                logic [15:0] imm16, logic [9:0] idx,
                                                logic [31:0] word);
    exec_result_t r;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  imm;
    logic [31:0]  res;
    logic [31:0]  addr;
    logic [31:0]  widx;
    logic [31:0]  pc_next;
    logic         wr;
    logic [4:0]   dst;
    r       = '0;
    imm     = {{16{imm16[15]}}, imm16};
    a       = gpr[rs];
    b       = gpr[rt];
    res     = '0;
    wr      = 1'b0;
    dst     = '0;
    if (cmd == CMD_LOAD) begin
      // image index is 10 bits wide, so it always lands inside the memory
      r.cls     = CLS_NOP;
      dmem[idx] = word;
    end else if (halted_q) begin
      r.cls = op_class(op);
      r.err = ERR_HALTED;
    end else begin
      r.cls   = op_class(op);
      pc_next = pc_q + 32'd4;
      case (op)
        OP_ADD:  begin res = a + b;   dst = rd; wr = 1'b1; end
        OP_ADDI: begin res = a + imm; dst = rt; wr = 1'b1; end
        OP_SUB:  begin res = a - b;   dst = rd; wr = 1'b1; end
        OP_SUBI: begin res = a - imm; dst = rt; wr = 1'b1; end
        OP_MUL:  begin res = a * b;   dst = rd; wr = 1'b1; end
        OP_MULI: begin res = a * imm; dst = rt; wr = 1'b1; end
        OP_OR:   begin res = a | b;   dst = rd; wr = 1'b1; end
        OP_ORI:  begin res = a | imm; dst = rt; wr = 1'b1; end
        OP_AND:  begin res = a & b;   dst = rd; wr = 1'b1; end
        OP_ANDI: begin res = a & imm; dst = rt; wr = 1'b1; end
        OP_XOR:  begin res = a ^ b;   dst = rd; wr = 1'b1; end
        OP_XORI: begin res = a ^ imm; dst = rt; wr = 1'b1; end
        OP_LDW, OP_STW: begin
          addr = a + imm;
          widx = addr >> 2;
          if (widx >= MEM_WORDS) begin
            r.err = ERR_RANGE;
          end else begin
            if (addr[1:0] != 2'b00) r.err = ERR_UNALIGNED;
            if (op == OP_LDW) begin
              res = dmem[widx[9:0]];
              dst = rt;
              wr  = 1'b1;
            end else begin
              dmem[widx[9:0]] = b;
              r.mw   = 1'b1;
              r.midx = widx[9:0];
              r.mval = b;
            end
          end
        end
        OP_BZ: begin
          if (a == 32'd0) begin
            pc_next = pc_q + {imm[29:0], 2'b00};
            r.taken = 1'b1;
          end
        end
        OP_BEQ: begin
          if (a == b) begin
            pc_next = pc_q + {imm[29:0], 2'b00};
            r.taken = 1'b1;
          end
        end
        OP_JR: begin
          pc_next = a;
          r.taken = 1'b1;
        end
        OP_HALT: halted_q = 1'b1;
        OP_NOP:  ;
        default: begin
          r.err    = ERR_UNKNOWN;
          halted_q = 1'b1;
          pc_next  = pc_q;
        end
      endcase
      // register zero is never written
      if (wr && dst != 5'd0) begin
        gpr[dst] = res;
        r.rw     = 1'b1;
        r.ridx   = dst;
        r.rval   = res;
      end
      pc_q = pc_next;
    end
    r.next_pc = pc_q;
    r.halted  = halted_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      for (int i = 0; i < MEM_WORDS; i++) dmem[i] = '0;
      pc_q     = '0;
      halted_q = 1'b0;
      expected_results.delete();
      fails    = 0;
      reported = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // output side first, so a stray result is never matched to this cycle's transfer
      if (out_valid_o && out_ready_i) begin
        got.next_pc = next_pc_o;
        got.halted  = halted_o;
        got.err     = error_code_o;
        got.taken   = branch_taken_o;
        got.rw      = reg_write_o;
        got.ridx    = reg_index_o;
        got.rval    = reg_value_o;
        got.mw      = mem_write_o;
        got.midx    = mem_index_o;
        got.mval    = mem_value_o;
        got.cls     = instr_class_o;
        if (expected_results.size() == 0) begin
          fails++;
          if (reported < 10) begin
            reported++;
            $display("unexpected result transfer: pc %h err %0d", got.next_pc, got.err);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.next_pc !== want.next_pc || got.halted !== want.halted ||
              got.err !== want.err || got.taken !== want.taken ||
              got.rw !== want.rw || got.ridx !== want.ridx || got.rval !== want.rval ||
              got.mw !== want.mw || got.midx !== want.midx || got.mval !== want.mval ||
              got.cls !== want.cls) begin
            fails++;
            if (reported < 10) begin
              reported++;
              $display("mismatch (exp/got): pc %h/%h halt %b/%b err %0d/%0d br %b/%b",
                       want.next_pc, got.next_pc, want.halted, got.halted,
                       want.err, got.err, want.taken, got.taken);
              $display("  rw %b/%b ridx %0d/%0d rval %h/%h mw %b/%b midx %0d/%0d",
                       want.rw, got.rw, want.ridx, got.ridx, want.rval, got.rval,
                       want.mw, got.mw, want.midx, got.midx);
              $display("  mval %h/%h cls %0d/%0d", want.mval, got.mval, want.cls, got.cls);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(execute_item(command_i, opcode_i, src_reg_i, second_reg_i,
                                                dest_reg_i, imm_value_i, image_index_i,
                                                image_word_i));
      end
      pending_o    <= expected_results.size();
      fail_count_o <= fails;
    end
  end

endmodule

### tb/tb_top.sv
// Testbench top of the MIPS-lite execute unit: clock, reset, stimulus, flow control and verdict.
module tb_top;
  import mlx_pkg::*;

  localparam int RANDOM_ITEMS   = 1950;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic               command_i     = CMD_LOAD;
  logic [4:0]         opcode_i      = '0;
  logic [4:0]         src_reg_i     = '0;
  logic [4:0]         second_reg_i  = '0;
  logic [4:0]         dest_reg_i    = '0;
  logic signed [15:0] imm_value_i   = '0;
  logic [9:0]         image_index_i = '0;
  logic [31:0]        image_word_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [31:0]        next_pc_o;
  logic               halted_o;
  logic [2:0]         error_code_o;
  logic               branch_taken_o;
  logic               reg_write_o;
  logic [4:0]         reg_index_o;
  logic signed [31:0] reg_value_o;
  logic               mem_write_o;
  logic [9:0]         mem_index_o;
  logic signed [31:0] mem_value_o;
  logic [2:0]         instr_class_o;

  int fail_count;
  int pending;
  int send_idle_pct = 19;
  int recv_idle_pct = 61;
  int phase         = 0;
  bit hold_done     = 1'b0;
  int sent          = 0;
  int idle_cycles   = 0;

  mips_lite_execute_unit u_top (.*);

  mlx_exec_checker u_checker (
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .*
  );

  always #4 clk_i = ~clk_i;

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off when the no-idle phase starts
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [4:0] rand_reg();
    return ($urandom_range(99) < 15) ? 5'd0 : 5'($urandom);
  endfunction

  function automatic logic [15:0] rand_imm();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one item and returns at the edge where it transfers.
  task automatic send_item(input logic cmd, input logic [4:0] op, input logic [4:0] rs,
                           input logic [4:0] rt, input logic [4:0] rd,
                           input logic [15:0] imm, input logic [9:0] idx,
                           input logic [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    opcode_i      <= op;
    src_reg_i     <= rs;
    second_reg_i  <= rt;
    dest_reg_i    <= rd;
    imm_value_i   <= imm;
    image_index_i <= idx;
    image_word_i  <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic exec_op(input logic [4:0] op, input logic [4:0] rs, input logic [4:0] rt,
                         input logic [4:0] rd, input logic [15:0] imm);
    send_item(CMD_EXEC, op, rs, rt, rd, imm, 10'($urandom), $urandom);
  endtask

  task automatic load_word(input logic [9:0] idx, input logic [31:0] word);
    send_item(CMD_LOAD, 5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
              16'($urandom), idx, word);
  endtask

  initial begin : stimulus
    int          pick;
    int          target;
    logic [4:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  base_reg;
    logic [31:0] base;
    logic [15:0] off;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, every operation but halt, register zero, alignment and range
    load_word(10'd0, 32'hFFFF_FFFF);
    load_word(10'd1023, 32'h8000_0000);
    exec_op(OP_ADDI, 5'd0, 5'd1, 5'd31, 16'h7FFF);
    exec_op(OP_ADDI, 5'd0, 5'd2, 5'd31, 16'h8000);
    exec_op(OP_ADD,  5'd1, 5'd2, 5'd3,  16'h0000);
    exec_op(OP_SUB,  5'd2, 5'd1, 5'd4,  16'h0000);
    exec_op(OP_SUBI, 5'd1, 5'd5, 5'd0,  16'hFFFF);
    exec_op(OP_MUL,  5'd2, 5'd2, 5'd6,  16'h0000);
    exec_op(OP_MULI, 5'd1, 5'd7, 5'd0,  16'h8000);
    exec_op(OP_OR,   5'd1, 5'd2, 5'd8,  16'h0000);
    exec_op(OP_ORI,  5'd2, 5'd9, 5'd0,  16'h00FF);
    exec_op(OP_AND,  5'd1, 5'd2, 5'd10, 16'h0000);
    exec_op(OP_ANDI, 5'd2, 5'd11, 5'd0, 16'hFFFF);
    exec_op(OP_XOR,  5'd1, 5'd2, 5'd12, 16'h0000);
    exec_op(OP_XORI, 5'd1, 5'd13, 5'd0, 16'h5555);
    exec_op(OP_ADD,  5'd1, 5'd1, 5'd0,  16'h0000);   // write to r0 dropped
    exec_op(OP_LDW,  5'd0, 5'd14, 5'd0, 16'd4092);   // last memory word
    exec_op(OP_LDW,  5'd0, 5'd0, 5'd0,  16'd0);      // load into r0 dropped
    exec_op(OP_LDW,  5'd0, 5'd15, 5'd0, 16'd1);      // unaligned
    exec_op(OP_STW,  5'd0, 5'd1, 5'd0,  16'd8);
    exec_op(OP_STW,  5'd0, 5'd2, 5'd0,  16'd4094);   // unaligned, last word
    exec_op(OP_LDW,  5'd1, 5'd16, 5'd0, 16'h7FFF);   // out of range beats unaligned
    exec_op(OP_BZ,   5'd0, 5'd0, 5'd0,  16'hFFFC);
    exec_op(OP_BEQ,  5'd1, 5'd1, 5'd0,  16'h7FFF);
    exec_op(OP_JR,   5'd1, 5'd0, 5'd0,  16'h0000);
    exec_op(OP_NOP,  5'd0, 5'd0, 5'd0,  16'h0000);

    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      if (phase == 0 && sent >= target - (2 * RANDOM_ITEMS) / 3) begin
        phase         = 1;
        send_idle_pct = 61;
        recv_idle_pct = 19;
      end else if (phase == 1 && sent >= target - RANDOM_ITEMS / 3) begin
        phase         = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 6) begin
        load_word(10'($urandom), $urandom);
      end else if (pick < 30) begin
        // point a register into memory, then access a word around it
        base_reg = 5'($urandom_range(1, 31));
        base     = $urandom_range(4095);
        if ($urandom_range(3) != 0) base[1:0] = 2'b00;
        exec_op(OP_ADDI, 5'd0, base_reg, rand_reg(), base[15:0]);
        off = 16'(($urandom_range(32) * 4) - 64);
        if ($urandom_range(7) == 0) off[1:0] = 2'($urandom);
        op = ($urandom_range(1) == 0) ? OP_LDW : OP_STW;
        exec_op(op, base_reg, rand_reg(), rand_reg(), off);
      end else begin
        // no halt here: it would end all execution for the rest of the run
        op = 5'($urandom_range(0, 17));
        if (op == OP_HALT) op = OP_NOP;
        rs = rand_reg();
        rt = rand_reg();
        if (op == OP_BEQ && $urandom_range(1) == 0) rt = rs;
        exec_op(op, rs, rt, rand_reg(), rand_imm());
      end
    end

    // unknown opcode halts the unit; afterwards only load commands still act
    exec_op(5'($urandom_range(19, 31)), rand_reg(), rand_reg(), rand_reg(), rand_imm());
    exec_op(OP_HALT, rand_reg(), rand_reg(), rand_reg(), rand_imm());
    repeat (40) begin
      if ($urandom_range(99) < 30) begin
        load_word(10'($urandom), $urandom);
      end else begin
        exec_op(5'($urandom), rand_reg(), rand_reg(), rand_reg(), rand_imm());
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
